>>> rtl/core/sorted_point_table_search_unit_assert.svh
// Assertion macros for the sorted point table search unit.
`ifndef SORTED_POINT_TABLE_SEARCH_UNIT_ASSERT_SVH
`define SORTED_POINT_TABLE_SEARCH_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clock, off during reset.
`define SPTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock, off during reset.
`define SPTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SPTS_ASSERT_NOW(label, ante, cons, msg)
`define SPTS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/core/spts_pkg.sv
// Package for the sorted point table search unit: payload types and constants.
package spts_pkg;

   localparam int TABLE_DEPTH_DEF  = 1024;
   localparam int COORD_WIDTH_DEF  = 32;
   localparam int COUNT_WIDTH      = 11;
   localparam int LOAD_IDX_WIDTH   = 10;
   localparam int MATCH_IDX_WIDTH  = 10;
   localparam int POINT_WIDTH      = 32;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic [LOAD_IDX_WIDTH-1:0]     load_index;
      logic signed [POINT_WIDTH-1:0] point_x;
      logic signed [POINT_WIDTH-1:0] point_y;
   } req_item_type;

   typedef struct packed {
      logic                       found;
      logic [MATCH_IDX_WIDTH-1:0] match_index;
   } rsp_item_type;

endpackage

>>> rtl/core/sorted_point_table_search_unit.sv
// Sorted point table search unit: point table memory and binary search sequencer.
//
// Usage:
//  - Request channel: drive req_payload and raise start; a request is taken at
//    a rising edge with start high and busy low.
//  - A load request (req_type 0) writes one (x, y) point into the table slot
//    load_index in that same edge; busy stays low, so loads go one per cycle.
//    Slots at or above TABLE_DEPTH are dropped. No response is produced.
//  - A lookup request (req_type 1) runs a binary search over the first
//    entry_count slots (clamped to TABLE_DEPTH). Each probe passes through
//    ST_READ for the registered table read, then ST_CMP for the key compare
//    and bound update in the single shared comparator. A lookup makes k
//    probes, k <= floor(log2(count)) + 1, and holds busy throughout;
//    the response strobe rsp_valid comes in the cycle busy drops.
//    An empty table answers not found in the cycle after the request.
//  - Response: rsp_valid is high for exactly one cycle with rsp_payload; the
//    receiver cannot stall it.
//  - csr_wr_en / csr_wr_data set entry_count; write only while idle.
//  - Reset (synchronous, active high) clears entry_count and the sequencer.
//    Table contents are not cleared and must be loaded before they are probed.
`include "sorted_point_table_search_unit_assert.svh"

module sorted_point_table_search_unit #(
   parameter int TABLE_DEPTH = spts_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_WIDTH = spts_pkg::COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  spts_pkg::req_item_type             req_payload,
   input  logic                               csr_wr_en,
   input  logic [spts_pkg::COUNT_WIDTH-1:0]   csr_wr_data,
   output logic                               rsp_valid,
   output spts_pkg::rsp_item_type             rsp_payload
);
   import spts_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int BW = IW + 1;
   localparam int CW = (BW > COUNT_WIDTH) ? BW : COUNT_WIDTH;
   localparam int MW = (IW > MATCH_IDX_WIDTH) ? IW : MATCH_IDX_WIDTH;
   localparam int LW = (CW > LOAD_IDX_WIDTH) ? CW : LOAD_IDX_WIDTH;
   localparam int EW = 2 * COORD_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP
   } state_type;

   state_type                      state_ff;
   logic [COUNT_WIDTH-1:0]         entry_count_ff;
   logic [BW-1:0]                  lo_ff;
   logic [BW-1:0]                  hi_ff;
   logic [BW-1:0]                  bound_ff;
   logic [IW-1:0]                  mid_ff;
   logic signed [COORD_WIDTH-1:0]  key_x_ff;
   logic signed [COORD_WIDTH-1:0]  key_y_ff;
   logic                           rsp_valid_ff;
   rsp_item_type                   rsp_ff;

   logic [EW-1:0]                  point_table_ff [TABLE_DEPTH];
   logic [EW-1:0]                  rd_data_ff;

   logic                           accept;
   logic                           load_we;
   logic [IW-1:0]                  load_addr;
   logic [BW-1:0]                  bound_in;
   logic [BW:0]                    mid_sum;
   logic [IW-1:0]                  mid_in;
   logic signed [COORD_WIDTH-1:0]  ent_x;
   logic signed [COORD_WIDTH-1:0]  ent_y;
   logic                           key_eq;
   logic                           key_gt;
   logic [BW-1:0]                  lo_in;
   logic [BW-1:0]                  hi_in;
   logic [MW-1:0]                  mid_wide;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Load slot range check done at a width that holds both the index and the depth.
   assign load_we   = accept && (req_payload.req_type == REQ_LOAD) &&
                      (LW'(req_payload.load_index) < LW'(TABLE_DEPTH));
   assign load_addr = IW'(req_payload.load_index);

   assign bound_in = (CW'(entry_count_ff) > CW'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH)
                                                              : BW'(entry_count_ff);

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_in  = mid_sum[IW:1];

   // Shared comparator: key against the entry just read.
   assign ent_x  = rd_data_ff[EW-1:COORD_WIDTH];
   assign ent_y  = rd_data_ff[COORD_WIDTH-1:0];
   assign key_eq = (key_x_ff == ent_x) && (key_y_ff == ent_y);
   assign key_gt = (key_x_ff > ent_x) || ((key_x_ff == ent_x) && (key_y_ff > ent_y));

   assign lo_in    = key_gt ? (BW'(mid_ff) + BW'(1)) : lo_ff;
   assign hi_in    = key_gt ? hi_ff : BW'(mid_ff);
   assign mid_wide = MW'(mid_ff);

   // Table memory: one write port for loads, one registered read port for probes.
   always_ff @(posedge clock) begin
      if (load_we) begin
         point_table_ff[load_addr] <= {req_payload.point_x[COORD_WIDTH-1:0],
                                       req_payload.point_y[COORD_WIDTH-1:0]};
      end
      rd_data_ff <= point_table_ff[mid_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_payload.req_type == REQ_LOOKUP)) begin
                  key_x_ff <= req_payload.point_x[COORD_WIDTH-1:0];
                  key_y_ff <= req_payload.point_y[COORD_WIDTH-1:0];
                  lo_ff    <= '0;
                  hi_ff    <= bound_in;
                  bound_ff <= bound_in;
                  if (bound_in == '0) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_ff.found       <= 1'b0;
                     rsp_ff.match_index <= '0;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               mid_ff   <= mid_in;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (key_eq) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.found       <= 1'b1;
                  rsp_ff.match_index <= mid_wide[MATCH_IDX_WIDTH-1:0];
                  state_ff           <= ST_IDLE;
               end else begin
                  lo_ff <= lo_in;
                  hi_ff <= hi_in;
                  if (lo_in >= hi_in) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_ff.found       <= 1'b0;
                     rsp_ff.match_index <= '0;
                     state_ff           <= ST_IDLE;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SPTS_ASSERT_NOW(a_rsp_only_idle, rsp_valid_ff, state_ff == ST_IDLE, "response while searching")
   `SPTS_ASSERT_NOW(a_hit_in_range, rsp_valid_ff && rsp_ff.found, BW'(mid_ff) < bound_ff, "hit beyond bound")
   `SPTS_ASSERT_NOW(a_miss_zero, rsp_valid_ff && !rsp_ff.found, rsp_ff.match_index == '0, "miss index not zero")
   `SPTS_ASSERT_NOW(a_interval_ok, state_ff != ST_IDLE, (lo_ff < hi_ff) && (hi_ff <= bound_ff), "bad search interval")
   `SPTS_ASSERT_NEXT(a_read_then_cmp, state_ff == ST_READ, state_ff == ST_CMP, "probe read not followed by compare")

endmodule
